// ----- sv/aap_pkg.sv -----
`default_nettype none
package aap_pkg;

    // default sizes of the plane store
    localparam int unsigned DEF_MAX_IN_HEIGHT = 64;
    localparam int unsigned DEF_MAX_IN_WIDTH  = 64;
    localparam int unsigned DEF_SAMPLE_BITS   = 16;

    // widths fixed by the register and field formats
    localparam int unsigned SIZE_W  = 7;
    localparam int unsigned CNT_W   = 14;
    localparam int unsigned IDX_W   = 8;
    localparam int unsigned AVG_W   = 16;
    localparam int unsigned WCNT_W  = 13;

    // register indexes
    localparam logic [IDX_W-1:0] CFG_IN_HEIGHT  = 8'd0;
    localparam logic [IDX_W-1:0] CFG_IN_WIDTH   = 8'd1;
    localparam logic [IDX_W-1:0] CFG_OUT_HEIGHT = 8'd2;
    localparam logic [IDX_W-1:0] CFG_OUT_WIDTH  = 8'd3;

    // item function codes
    localparam logic FUNC_STORE = 1'b0;
    localparam logic FUNC_POOL  = 1'b1;

    typedef struct packed {
        logic               func;
        logic [5:0]         pixel_row;
        logic [5:0]         pixel_col;
        logic signed [15:0] pixel_value;
        logic [5:0]         out_row;
        logic [5:0]         out_col;
    } t_in_item;

    typedef struct packed {
        logic signed [AVG_W-1:0] average;
        logic [WCNT_W-1:0]       window_count;
    } t_out_item;

endpackage
`default_nettype wire

// ----- sv/aap_plane_mem.sv -----
`default_nettype none
module aap_plane_mem #(
    parameter int unsigned DEPTH  = 4096,
    parameter int unsigned ADDR_W = 12,
    parameter int unsigned DATA_W = 16
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire [ADDR_W-1:0]         i_waddr,
    input  wire signed [DATA_W-1:0]  i_wdata,
    input  wire [ADDR_W-1:0]         i_raddr,
    output logic signed [DATA_W-1:0] o_rdata
);

    logic signed [DATA_W-1:0] r_mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// ----- sv/aap_div.sv -----
`default_nettype none
module aap_div #(
    parameter int unsigned NW = 31,
    parameter int unsigned DW = 14
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_start,
    input  wire  [NW-1:0]     i_num,
    input  wire  [DW-1:0]     i_den,
    output logic              o_done,
    output logic [NW-1:0]     o_quo
);

    localparam int unsigned CW = $clog2(NW + 1);

    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_den;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic [DW:0]   rem_sh;
    logic [DW:0]   rem_sub;

    // one restoring step per cycle
    always_comb begin
        rem_sh  = {r_rem, o_quo[NW-1]};
        rem_sub = rem_sh - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NW);
                r_rem  <= '0;
                r_den  <= i_den;
                o_quo  <= i_num;
            end else if (r_busy) begin
                if (!rem_sub[DW]) begin
                    r_rem <= rem_sub[DW-1:0];
                    o_quo <= {o_quo[NW-2:0], 1'b1};
                end else begin
                    r_rem <= rem_sh[DW-1:0];
                    o_quo <= {o_quo[NW-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

endmodule
`default_nettype wire

// ----- sv/adaptive_average_pool_2d.sv -----
`default_nettype none
// channel   direction  handshake          payload
// in        input      valid / stall      aap_pkg::t_in_item
// out       output     valid / stall      aap_pkg::t_out_item
// cfg       input      valid / ready      register index, 7-bit value
//
// a store item is taken without stalling. a pool item keeps the input stalled
// from its accept until its result is written to the output register, so no
// new item is taken while a pool item is in work:
// one shared serial divider forms the four window bounds and the average,
// and the window is read from the plane memory one sample per cycle.
// reset is synchronous, sets the size registers to 1 and clears control; the
// plane is not cleared. a finished result waits in the output register while
// the next item is taken; a pool item finishing behind a stalled result waits for it.
module adaptive_average_pool_2d #(
    parameter int unsigned MAX_IN_HEIGHT = aap_pkg::DEF_MAX_IN_HEIGHT,
    parameter int unsigned MAX_IN_WIDTH  = aap_pkg::DEF_MAX_IN_WIDTH,
    parameter int unsigned SAMPLE_BITS   = aap_pkg::DEF_SAMPLE_BITS
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_in_valid,
    output logic                               o_in_stall,
    input  wire aap_pkg::t_in_item             i_in_item,
    output logic                               o_out_valid,
    input  wire                                i_out_stall,
    output aap_pkg::t_out_item                 o_out_item,
    input  wire                                i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire  [aap_pkg::IDX_W-1:0]          i_cfg_index,
    input  wire  [aap_pkg::SIZE_W-1:0]         i_cfg_data
);

    localparam int unsigned DEPTH  = MAX_IN_HEIGHT * MAX_IN_WIDTH;
    localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned SW     = aap_pkg::SIZE_W;
    localparam int unsigned CW     = aap_pkg::CNT_W;
    localparam int unsigned NW     = SAMPLE_BITS + CW + 1;

    typedef enum logic [2:0] {
        S_IDLE, S_BOUND, S_BWAIT, S_SCAN, S_DRAIN, S_FDIV, S_FWAIT, S_DONE
    } t_state;

    t_state r_state;
    logic [SW-1:0] r_in_h, r_in_w, r_out_h, r_out_w;
    logic [SW-1:0] r_ih, r_iw, r_oh_sz, r_ow_sz;
    logic [5:0]    r_oh, r_ow;
    logic [1:0]    r_step;
    logic [SW-1:0] r_r0, r_r1, r_c0, r_c1, r_r, r_c;
    logic          r_rd_pend;
    logic signed [NW-1:0] r_sum;
    logic          r_neg;
    logic [CW-1:0] r_count;
    logic          r_out_valid;
    aap_pkg::t_out_item r_out_item;

    logic          in_acc, mem_we, div_start, div_done;
    logic [NW-1:0] div_num, div_quo;
    logic [CW-1:0] div_den;
    logic [ADDR_W-1:0] waddr, raddr;
    logic signed [SAMPLE_BITS-1:0] wdata, rdata;
    logic [SW-1:0] ih_c, iw_c, oh_c, ow_c;
    logic [NW-1:0] sum_mag;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;
    assign in_acc      = i_in_valid && !o_in_stall;

    // clamp the size registers to their working ranges
    always_comb begin
        ih_c = (r_in_h == '0) ? SW'(1) : r_in_h;
        if (32'(ih_c) > MAX_IN_HEIGHT) ih_c = SW'(MAX_IN_HEIGHT);
        iw_c = (r_in_w == '0) ? SW'(1) : r_in_w;
        if (32'(iw_c) > MAX_IN_WIDTH) iw_c = SW'(MAX_IN_WIDTH);
        oh_c = (r_out_h == '0) ? SW'(1) : r_out_h;
        ow_c = (r_out_w == '0) ? SW'(1) : r_out_w;
    end

    // store path into the plane memory
    assign mem_we = in_acc && (i_in_item.func == aap_pkg::FUNC_STORE)
                 && (32'(i_in_item.pixel_row) < MAX_IN_HEIGHT)
                 && (32'(i_in_item.pixel_col) < MAX_IN_WIDTH);
    assign waddr = ADDR_W'(32'(i_in_item.pixel_row) * MAX_IN_WIDTH
                 + 32'(i_in_item.pixel_col));
    assign wdata = SAMPLE_BITS'(i_in_item.pixel_value);
    assign raddr = ADDR_W'(32'(r_r) * MAX_IN_WIDTH + 32'(r_c));

    aap_plane_mem #(.DEPTH(DEPTH), .ADDR_W(ADDR_W), .DATA_W(SAMPLE_BITS)) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // divider operands: window bounds, then the average
    always_comb begin
        div_start = (r_state == S_BOUND) || (r_state == S_FDIV);
        div_num   = '0;
        div_den   = CW'(1);
        sum_mag   = r_sum[NW-1] ? NW'(-r_sum) : NW'(r_sum);
        if (r_state == S_FDIV) begin
            div_num = sum_mag;
            div_den = r_count;
        end else begin
            case (r_step)
                2'd0: begin
                    div_num = NW'(CW'(r_oh) * CW'(r_ih));
                    div_den = CW'(r_oh_sz);
                end
                2'd1: begin
                    div_num = NW'((CW'(r_oh) + CW'(1)) * CW'(r_ih) + CW'(r_oh_sz) - CW'(1));
                    div_den = CW'(r_oh_sz);
                end
                2'd2: begin
                    div_num = NW'(CW'(r_ow) * CW'(r_iw));
                    div_den = CW'(r_ow_sz);
                end
                default: begin
                    div_num = NW'((CW'(r_ow) + CW'(1)) * CW'(r_iw) + CW'(r_ow_sz) - CW'(1));
                    div_den = CW'(r_ow_sz);
                end
            endcase
        end
    end

    aap_div #(.NW(NW), .DW(CW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // sequencer, configuration and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_in_h      <= SW'(1);
            r_in_w      <= SW'(1);
            r_out_h     <= SW'(1);
            r_out_w     <= SW'(1);
            r_out_valid <= 1'b0;
            r_rd_pend   <= 1'b0;
            r_step      <= '0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    aap_pkg::CFG_IN_HEIGHT:  r_in_h  <= i_cfg_data;
                    aap_pkg::CFG_IN_WIDTH:   r_in_w  <= i_cfg_data;
                    aap_pkg::CFG_OUT_HEIGHT: r_out_h <= i_cfg_data;
                    aap_pkg::CFG_OUT_WIDTH:  r_out_w <= i_cfg_data;
                    default: ;
                endcase
            end
            // output register empties when taken, unless a new item replaces it
            if (r_out_valid && !i_out_stall && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            // accumulate the sample read in the previous cycle
            if (r_rd_pend) begin
                r_sum <= r_sum + NW'(rdata);
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc && i_in_item.func == aap_pkg::FUNC_POOL
                        && SW'(i_in_item.out_row) < oh_c
                        && SW'(i_in_item.out_col) < ow_c) begin
                        r_ih    <= ih_c;
                        r_iw    <= iw_c;
                        r_oh_sz <= oh_c;
                        r_ow_sz <= ow_c;
                        r_oh    <= i_in_item.out_row;
                        r_ow    <= i_in_item.out_col;
                        r_step  <= '0;
                        r_state <= S_BOUND;
                    end
                end
                S_BOUND: r_state <= S_BWAIT;
                S_BWAIT: begin
                    if (div_done) begin
                        case (r_step)
                            2'd0:    r_r0 <= div_quo[SW-1:0];
                            2'd1:    r_r1 <= div_quo[SW-1:0];
                            2'd2:    r_c0 <= div_quo[SW-1:0];
                            default: r_c1 <= div_quo[SW-1:0];
                        endcase
                        if (r_step == 2'd3) begin
                            r_r     <= r_r0;
                            r_c     <= r_c0;
                            r_sum   <= '0;
                            r_count <= CW'(r_r1 - r_r0) * CW'(div_quo[SW-1:0] - r_c0);
                            r_state <= S_SCAN;
                        end else begin
                            r_step  <= r_step + 2'd1;
                            r_state <= S_BOUND;
                        end
                    end
                end
                // one window sample read per cycle
                S_SCAN: begin
                    r_rd_pend <= 1'b1;
                    if (r_c + SW'(1) == r_c1) begin
                        r_c <= r_c0;
                        r_r <= r_r + SW'(1);
                        if (r_r + SW'(1) == r_r1) begin
                            r_state <= S_DRAIN;
                        end
                    end else begin
                        r_c <= r_c + SW'(1);
                    end
                end
                S_DRAIN: begin
                    r_rd_pend <= 1'b0;
                    r_state   <= S_FDIV;
                end
                S_FDIV: begin
                    r_neg   <= r_sum[NW-1];
                    r_state <= S_FWAIT;
                end
                S_FWAIT: begin
                    if (div_done) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid <= 1'b1;
                        r_out_item.window_count <= r_count[aap_pkg::WCNT_W-1:0];
                        if (!r_neg) begin
                            r_out_item.average <= (div_quo > NW'(32767))
                                ? 16'sd32767 : div_quo[15:0];
                        end else begin
                            r_out_item.average <= (div_quo > NW'(32768))
                                ? -16'sd32768 : 16'(-div_quo);
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire
